// ===== rtl/core/stack_vm_256bit_executor_core_assert.svh =====
// Assertion macros for the stack machine executor.
`ifndef STACK_VM_256BIT_EXECUTOR_CORE_ASSERT_SVH
`define STACK_VM_256BIT_EXECUTOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SVM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SVM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SVM_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define SVM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/core/svm_pkg.sv =====
// Shared types, constants and opcodes of the stack machine executor.
`default_nettype none
package svm_pkg;
   localparam int unsigned STACK_WORDS   = 1024;
   localparam int unsigned PROGRAM_BYTES = 65536;
   localparam int unsigned DEPTH_W       = $clog2(STACK_WORDS + 1);
   localparam int unsigned ADDR_W        = $clog2(STACK_WORDS);
   localparam int unsigned PC_W          = $clog2(PROGRAM_BYTES) + 1;
   localparam logic [63:0] BASE_GAS      = 64'd21000;
   localparam logic [63:0] GAS_RESET     = 64'd30000000;

   localparam logic [7:0] OP_STOP   = 8'h00;
   localparam logic [7:0] OP_ADD    = 8'h01;
   localparam logic [7:0] OP_MUL    = 8'h02;
   localparam logic [7:0] OP_SUB    = 8'h03;
   localparam logic [7:0] OP_LT     = 8'h10;
   localparam logic [7:0] OP_GT     = 8'h11;
   localparam logic [7:0] OP_EQ     = 8'h14;
   localparam logic [7:0] OP_ISZERO = 8'h15;
   localparam logic [7:0] OP_AND    = 8'h16;
   localparam logic [7:0] OP_OR     = 8'h17;
   localparam logic [7:0] OP_XOR    = 8'h18;
   localparam logic [7:0] OP_NOT    = 8'h19;
   localparam logic [7:0] OP_SHL    = 8'h1B;
   localparam logic [7:0] OP_SHR    = 8'h1C;
   localparam logic [7:0] OP_GASLIM = 8'h45;
   localparam logic [7:0] OP_POP    = 8'h50;
   localparam logic [7:0] OP_PC     = 8'h58;
   localparam logic [7:0] OP_GAS    = 8'h5A;
   localparam logic [7:0] OP_PUSH1  = 8'h60;
   localparam logic [7:0] OP_PUSH32 = 8'h7F;
   localparam logic [7:0] OP_DUP1   = 8'h80;
   localparam logic [7:0] OP_DUP16  = 8'h8F;
   localparam logic [7:0] OP_SWAP1  = 8'h90;
   localparam logic [7:0] OP_SWAP16 = 8'h9F;
   localparam logic [7:0] OP_INVAL  = 8'hFE;
   localparam logic [7:0] OP_SDEST  = 8'hFF;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_STOPPED = 3'd1,
      ST_INVALID = 3'd2,
      ST_UNDER   = 3'd3,
      ST_OVER    = 3'd4,
      ST_HALTED  = 3'd5,
      ST_UNSUPP  = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      ALU_ZERO, ALU_ADD, ALU_SUB, ALU_LT, ALU_GT, ALU_EQ, ALU_ISZ, ALU_LOGIC
   } alu_type;

   typedef enum logic [3:0] {
      S_IDLE, S_RDA, S_RDB, S_OPND, S_EXEC, S_MUL, S_WR, S_WR2, S_RDTOP, S_TOPW, S_OUT
   } state_type;

   typedef struct packed {
      logic        rd;
      logic        wr;
      logic [1:0]  addr_sel;   // 0: depth-1, 1: depth-2/depth-need, 2: depth
      logic        wr_src;     // 0: result, 1: operand a (swap)
      logic [1:0]  dst;        // capture into 0: a, 1: b, 2: top
      logic        exec;
      logic        mul_start;
      logic        zero_top;
   } dp_cmd_type;

   typedef struct packed {
      logic mul_done;
   } dp_sts_type;

   function automatic logic [255:0] shift256(input logic [255:0] v, input logic [255:0] amt,
                                             input logic left);
      logic [255:0] r;
      begin
         if (amt[255:8] != '0) r = '0;
         else if (left) r = v << amt[7:0];
         else r = v >> amt[7:0];
         return r;
      end
   endfunction
endpackage
`default_nettype wire

// ===== rtl/core/stack_vm_256bit_executor_core.sv =====
// Top level of the 256-bit stack machine executor.
// Rejected or halting instructions go from S_RDA straight to S_RDTOP; SWAP adds a second write (S_WR2);
// MUL runs 36 32x32 partial products, one a cycle, before the result is written.
// One transaction at a time: a new request is taken only after the response has been accepted.
// Reset is synchronous: empty stack, pc 0, gas 30000000 minus 21000; stack memory
// contents are undefined until written.
`default_nettype none
`include "stack_vm_256bit_executor_core_assert.svh"
module stack_vm_256bit_executor_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [63:0] csr_wdata,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_mode,
   input  wire logic [63:0] req_imm_w0,
   input  wire logic [63:0] req_imm_w1,
   input  wire logic [63:0] req_imm_w2,
   input  wire logic [63:0] req_imm_w3,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [63:0]      rsp_top_w0,
   output logic [63:0]      rsp_top_w1,
   output logic [63:0]      rsp_top_w2,
   output logic [63:0]      rsp_top_w3,
   output logic [10:0]      rsp_stack_count,
   output logic [63:0]      rsp_gas_left,
   output logic [15:0]      rsp_next_pc
);
   svm_pkg::dp_cmd_type cmd;
   svm_pkg::dp_sts_type sts;
   logic [7:0]   op;
   logic [63:0]  gas_limit, gas_now;
   logic [15:0]  pc_now;
   logic [svm_pkg::DEPTH_W-1:0] depth;
   logic [4:0]   need;
   logic [255:0] imm_ff, top;

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) imm_ff <= {req_imm_w3, req_imm_w2, req_imm_w1, req_imm_w0};
   end

   svm_ctrl u_ctrl (
      .clock, .reset, .csr_we, .csr_wdata, .req_valid, .req_ready, .req_mode,
      .rsp_valid, .rsp_ready, .rsp_status, .rsp_stack_count, .rsp_gas_left,
      .rsp_next_pc, .cmd, .sts, .op, .gas_limit, .gas_now, .pc_now, .depth, .need
   );

   svm_datapath u_dp (
      .clock, .reset, .cmd, .sts, .op, .imm(imm_ff), .gas_limit, .gas_now, .pc_now,
      .depth, .need, .top
   );

   assign rsp_top_w0 = top[63:0];
   assign rsp_top_w1 = top[127:64];
   assign rsp_top_w2 = top[191:128];
   assign rsp_top_w3 = top[255:192];

   `SVM_ASSERT_IMPL(a_no_overlap, clock, reset, req_ready, !rsp_valid, "request taken while a response is pending")
   `SVM_ASSERT_IMPL(a_no_rd_wr, clock, reset, cmd.wr, !cmd.rd, "stack memory read and write in one cycle")
   `SVM_ASSERT_NEXT(a_rsp_done, clock, reset, rsp_valid && rsp_ready && !csr_we, req_ready, "controller did not return to idle")
endmodule
`default_nettype wire

// ===== rtl/core/svm_datapath.sv =====
// Datapath: stack memory, operand registers, ALU and limb-serial multiplier.
`default_nettype none
module svm_datapath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire svm_pkg::dp_cmd_type   cmd,
   output svm_pkg::dp_sts_type        sts,
   input  wire logic [7:0]            op,
   input  wire logic [255:0]          imm,
   input  wire logic [63:0]           gas_limit,
   input  wire logic [63:0]           gas_now,
   input  wire logic [15:0]           pc_now,
   input  wire logic [svm_pkg::DEPTH_W-1:0] depth,
   input  wire logic [4:0]            need,
   output logic [255:0]               top
);
   logic [255:0] mem [svm_pkg::STACK_WORDS];
   logic [255:0] rd_ff;
   logic [255:0] a_ff, a_in, b_ff, r_ff, r_in;
   logic [255:0] top_ff;
   logic [1:0]   dst_ff;
   logic         cap_ff;
   logic [svm_pkg::DEPTH_W-1:0] addr_full;
   logic [svm_pkg::ADDR_W-1:0]  addr;
   logic [255:0] wdata;
   logic [2:0]   mi_ff, mj_ff, mi_in, mj_in;
   logic [3:0]   msum;
   logic         mbusy_ff, mbusy_in;
   logic [255:0] macc_ff, macc_in;
   logic [63:0]  prod;
   logic [31:0]  op_a, op_b;
   logic [7:0]   nbits;
   logic [255:0] mask;

   always_comb begin
      case (cmd.addr_sel)
         2'd0: addr_full = depth - svm_pkg::DEPTH_W'(1);
         2'd1: addr_full = depth - svm_pkg::DEPTH_W'(need);
         default: addr_full = depth;
      endcase
      addr = addr_full[svm_pkg::ADDR_W-1:0];
      wdata = cmd.wr_src ? a_ff : r_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.wr) mem[addr] <= wdata;
      if (cmd.rd) rd_ff <= mem[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= 1'b0;
         dst_ff <= '0;
      end else begin
         cap_ff <= cmd.rd;
         dst_ff <= cmd.dst;
      end
   end

   always_comb begin
      nbits = 8'((op - svm_pkg::OP_PUSH1) + 8'd1) << 3;
      mask  = (nbits == 8'd0) ? {256{1'b1}} : ((256'd1 << nbits) - 256'd1);
      r_in = '0;
      case (op)
         svm_pkg::OP_ADD:    r_in = a_ff + b_ff;
         svm_pkg::OP_SUB:    r_in = a_ff - b_ff;
         svm_pkg::OP_LT:     r_in = {255'd0, a_ff < b_ff};
         svm_pkg::OP_GT:     r_in = {255'd0, a_ff > b_ff};
         svm_pkg::OP_EQ:     r_in = {255'd0, a_ff == b_ff};
         svm_pkg::OP_ISZERO: r_in = {255'd0, a_ff == '0};
         svm_pkg::OP_AND:    r_in = a_ff & b_ff;
         svm_pkg::OP_OR:     r_in = a_ff | b_ff;
         svm_pkg::OP_XOR:    r_in = a_ff ^ b_ff;
         svm_pkg::OP_NOT:    r_in = ~a_ff;
         svm_pkg::OP_SHL:    r_in = svm_pkg::shift256(b_ff, a_ff, 1'b1);
         svm_pkg::OP_SHR:    r_in = svm_pkg::shift256(b_ff, a_ff, 1'b0);
         svm_pkg::OP_GASLIM: r_in = {192'd0, gas_limit};
         svm_pkg::OP_PC:     r_in = {240'd0, pc_now};
         svm_pkg::OP_GAS:    r_in = {192'd0, gas_now};
         default: begin
            if (op >= svm_pkg::OP_PUSH1 && op <= svm_pkg::OP_PUSH32) r_in = imm & mask;
            else if (op >= svm_pkg::OP_SWAP1 && op <= svm_pkg::OP_SWAP16) r_in = b_ff;
            else r_in = a_ff;
         end
      endcase
   end

   // Schoolbook multiply over eight 32-bit half-limbs, one partial product per cycle (i+j<8).
   always_comb begin
      op_a = a_ff[32*mi_ff +: 32];
      op_b = b_ff[32*mj_ff +: 32];
      prod = op_a * op_b;
      msum = {1'b0, mi_ff} + {1'b0, mj_ff};
      macc_in = macc_ff;
      mi_in = mi_ff;
      mj_in = mj_ff;
      mbusy_in = mbusy_ff;
      if (cmd.mul_start) begin
         macc_in = '0;
         mi_in = '0;
         mj_in = '0;
         mbusy_in = 1'b1;
      end else if (mbusy_ff) begin
         macc_in = macc_ff + ({192'd0, prod} << {msum, 5'd0});
         if (msum == 4'd7) begin
            mj_in = '0;
            if (mi_ff == 3'd7) mbusy_in = 1'b0;
            else mi_in = mi_ff + 3'd1;
         end else begin
            mj_in = mj_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mbusy_ff <= 1'b0;
         mi_ff <= '0;
         mj_ff <= '0;
      end else begin
         mbusy_ff <= mbusy_in;
         mi_ff <= mi_in;
         mj_ff <= mj_in;
      end
      macc_ff <= macc_in;
   end

   assign sts.mul_done = !mbusy_ff && !cmd.mul_start;

   always_comb begin
      a_in = a_ff;
      if (cap_ff && dst_ff == 2'd0) a_in = rd_ff;
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      if (cap_ff && dst_ff == 2'd1) b_ff <= rd_ff;
      if (cmd.exec) r_ff <= (op == svm_pkg::OP_MUL) ? macc_ff : r_in;
      if (cmd.zero_top) top_ff <= '0;
      else if (cap_ff && dst_ff == 2'd2) top_ff <= rd_ff;
   end

   assign top = top_ff;
endmodule
`default_nettype wire

// ===== rtl/core/svm_ctrl.sv =====
// Controller: decode, checks, gas, pc, depth and the sequencing state machine.
`default_nettype none
module svm_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [63:0]           csr_wdata,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [7:0]            req_mode,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [2:0]                 rsp_status,
   output logic [10:0]                rsp_stack_count,
   output logic [63:0]                rsp_gas_left,
   output logic [15:0]                rsp_next_pc,
   output svm_pkg::dp_cmd_type        cmd,
   input  wire svm_pkg::dp_sts_type   sts,
   output logic [7:0]                 op,
   output logic [63:0]                gas_limit,
   output logic [63:0]                gas_now,
   output logic [15:0]                pc_now,
   output logic [svm_pkg::DEPTH_W-1:0] depth,
   output logic [4:0]                 need
);
   svm_pkg::state_type state_ff, state_in;
   logic [7:0]  op_ff;
   logic [63:0] limit_ff, gas_ff, gas_in;
   logic [15:0] pc_ff, pc_in;
   logic [svm_pkg::DEPTH_W-1:0] depth_ff, depth_in;
   logic        halt_ff, halt_in;
   svm_pkg::status_type st_ff, st_in;
   logic [4:0]  need_c;
   logic [5:0]  adv_c;
   logic [63:0] cost_c;
   logic        grows_c, known_c, swap_c, dup_c, pop_c;
   logic [16:0] newpc;

   always_comb begin
      need_c = '0; cost_c = 64'd3; adv_c = 6'd1;
      grows_c = 1'b0; known_c = 1'b1;
      swap_c = 1'b0; dup_c = 1'b0; pop_c = 1'b0;
      case (op_ff)
         svm_pkg::OP_ADD, svm_pkg::OP_SUB, svm_pkg::OP_LT, svm_pkg::OP_GT,
         svm_pkg::OP_EQ, svm_pkg::OP_AND, svm_pkg::OP_OR, svm_pkg::OP_XOR,
         svm_pkg::OP_SHL, svm_pkg::OP_SHR: need_c = 5'd2;
         svm_pkg::OP_MUL: begin need_c = 5'd2; cost_c = 64'd5; end
         svm_pkg::OP_ISZERO, svm_pkg::OP_NOT: need_c = 5'd1;
         svm_pkg::OP_POP: begin need_c = 5'd1; cost_c = 64'd2; pop_c = 1'b1; end
         svm_pkg::OP_GASLIM, svm_pkg::OP_PC, svm_pkg::OP_GAS: begin
            grows_c = 1'b1; cost_c = 64'd2;
         end
         default: begin
            if (op_ff >= svm_pkg::OP_PUSH1 && op_ff <= svm_pkg::OP_PUSH32) begin
               grows_c = 1'b1;
               adv_c = 6'(op_ff - svm_pkg::OP_PUSH1) + 6'd2;
            end else if (op_ff >= svm_pkg::OP_DUP1 && op_ff <= svm_pkg::OP_DUP16) begin
               grows_c = 1'b1; dup_c = 1'b1;
               need_c = 5'(op_ff - svm_pkg::OP_DUP1) + 5'd1;
            end else if (op_ff >= svm_pkg::OP_SWAP1 && op_ff <= svm_pkg::OP_SWAP16) begin
               swap_c = 1'b1;
               need_c = 5'(op_ff - svm_pkg::OP_SWAP1) + 5'd2;
            end else known_c = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      gas_in = gas_ff; pc_in = pc_ff; depth_in = depth_ff;
      halt_in = halt_ff; st_in = st_ff;
      cmd = '0;
      newpc = {1'b0, pc_ff} + 17'(adv_c);
      req_ready = (state_ff == svm_pkg::S_IDLE);
      rsp_valid = (state_ff == svm_pkg::S_OUT);
      case (state_ff)
         svm_pkg::S_IDLE: if (req_valid) state_in = svm_pkg::S_RDA;
         svm_pkg::S_RDA: begin
            if (halt_ff) begin
               st_in = svm_pkg::ST_HALTED; state_in = svm_pkg::S_RDTOP;
            end else if (op_ff == svm_pkg::OP_STOP || op_ff == svm_pkg::OP_SDEST ||
                         op_ff == svm_pkg::OP_INVAL) begin
               st_in = (op_ff == svm_pkg::OP_INVAL) ? svm_pkg::ST_INVALID
                                                    : svm_pkg::ST_STOPPED;
               halt_in = 1'b1; state_in = svm_pkg::S_RDTOP;
            end else if (!known_c) begin
               st_in = svm_pkg::ST_UNSUPP; state_in = svm_pkg::S_RDTOP;
            end else if (depth_ff < svm_pkg::DEPTH_W'(need_c)) begin
               st_in = svm_pkg::ST_UNDER; state_in = svm_pkg::S_RDTOP;
            end else if (grows_c && depth_ff >= svm_pkg::DEPTH_W'(svm_pkg::STACK_WORDS)) begin
               st_in = svm_pkg::ST_OVER; state_in = svm_pkg::S_RDTOP;
            end else begin
               st_in = svm_pkg::ST_OK;
               gas_in = gas_ff - cost_c;
               if (newpc >= 17'(svm_pkg::PROGRAM_BYTES)) halt_in = 1'b1;
               pc_in = newpc[15:0];
               if (need_c != '0) begin
                  cmd.rd = 1'b1;
                  cmd.addr_sel = dup_c ? 2'd1 : 2'd0;
                  cmd.dst = 2'd0;
               end
               state_in = svm_pkg::S_RDB;
            end
         end
         svm_pkg::S_RDB: begin
            if (need_c >= 5'd2 && !dup_c) begin
               cmd.rd = 1'b1; cmd.addr_sel = 2'd1; cmd.dst = 2'd1;
            end
            state_in = svm_pkg::S_OPND;
         end
         svm_pkg::S_OPND: state_in = svm_pkg::S_EXEC;
         svm_pkg::S_EXEC: begin
            if (op_ff == svm_pkg::OP_MUL) begin
               cmd.mul_start = 1'b1; state_in = svm_pkg::S_MUL;
            end else begin
               cmd.exec = 1'b1; state_in = svm_pkg::S_WR;
            end
         end
         svm_pkg::S_MUL: if (sts.mul_done) begin
            cmd.exec = 1'b1; state_in = svm_pkg::S_WR;
         end
         svm_pkg::S_WR: begin
            if (swap_c) begin
               cmd.wr = 1'b1; cmd.addr_sel = 2'd1; cmd.wr_src = 1'b1;
               state_in = svm_pkg::S_WR2;
            end else begin
               if (pop_c) depth_in = depth_ff - svm_pkg::DEPTH_W'(1);
               else if (grows_c) begin
                  cmd.wr = 1'b1; cmd.addr_sel = 2'd2;
                  depth_in = depth_ff + svm_pkg::DEPTH_W'(1);
               end else if (need_c == 5'd2) begin
                  cmd.wr = 1'b1; cmd.addr_sel = 2'd1;
                  depth_in = depth_ff - svm_pkg::DEPTH_W'(1);
               end else begin
                  cmd.wr = 1'b1; cmd.addr_sel = 2'd0;
               end
               state_in = svm_pkg::S_RDTOP;
            end
         end
         svm_pkg::S_WR2: begin
            // Second half of a swap: the deeper word lands on top.
            cmd.wr = 1'b1; cmd.addr_sel = 2'd0; cmd.wr_src = 1'b0;
            state_in = svm_pkg::S_RDTOP;
         end
         svm_pkg::S_RDTOP: begin
            if (depth_ff == '0) cmd.zero_top = 1'b1;
            else begin
               cmd.rd = 1'b1; cmd.addr_sel = 2'd0; cmd.dst = 2'd2;
            end
            state_in = svm_pkg::S_TOPW;
         end
         svm_pkg::S_TOPW: state_in = svm_pkg::S_OUT;
         svm_pkg::S_OUT: if (rsp_ready) state_in = svm_pkg::S_IDLE;
         default: state_in = svm_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= svm_pkg::S_IDLE;
         limit_ff <= svm_pkg::GAS_RESET;
         gas_ff <= svm_pkg::GAS_RESET - svm_pkg::BASE_GAS;
         pc_ff <= '0;
         depth_ff <= '0;
         halt_ff <= 1'b0;
         st_ff <= svm_pkg::ST_OK;
      end else if (csr_we) begin
         limit_ff <= csr_wdata;
         gas_ff <= csr_wdata - svm_pkg::BASE_GAS;
         pc_ff <= '0;
         depth_ff <= '0;
         halt_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         gas_ff <= gas_in;
         pc_ff <= pc_in;
         depth_ff <= depth_in;
         halt_ff <= halt_in;
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) op_ff <= req_mode;
   end

   assign op = op_ff;
   assign gas_limit = limit_ff;
   assign gas_now = gas_ff;
   assign pc_now = pc_ff - 16'(adv_c);
   assign depth = depth_ff;
   assign need = need_c;
   assign rsp_status = st_ff;
   assign rsp_stack_count = 11'(depth_ff);
   assign rsp_gas_left = gas_ff;
   assign rsp_next_pc = pc_ff;
endmodule
`default_nettype wire

// ===== tb/stack_vm_256bit_executor_core_checker.sv =====
// Checker that predicts and compares every result transaction of the stack machine.
`timescale 1ns / 100ps
`default_nettype none
module stack_vm_256bit_executor_core_checker
   import svm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [63:0] csr_wdata,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [7:0]  req_mode,
   input  wire logic [63:0] req_imm_w0,
   input  wire logic [63:0] req_imm_w1,
   input  wire logic [63:0] req_imm_w2,
   input  wire logic [63:0] req_imm_w3,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [2:0]  rsp_status,
   input  wire logic [63:0] rsp_top_w0,
   input  wire logic [63:0] rsp_top_w1,
   input  wire logic [63:0] rsp_top_w2,
   input  wire logic [63:0] rsp_top_w3,
   input  wire logic [10:0] rsp_stack_count,
   input  wire logic [63:0] rsp_gas_left,
   input  wire logic [15:0] rsp_next_pc,
   output int               mismatch_count,
   output int               pending_count
);

   typedef struct {
      status_type  status;
      logic [255:0] top;
      logic [10:0] count;
      logic [63:0] gas;
      logic [15:0] pc;
   } vm_result_t;

   logic [255:0] stack_words [STACK_WORDS];
   int unsigned  depth;
   logic [15:0]  pc;
   logic [63:0]  gas;
   logic [63:0]  gas_limit;
   bit           halted;
   vm_result_t   expected_results [$];

   function automatic void restart_machine();
      depth  = 0;
      pc     = '0;
      gas    = gas_limit - BASE_GAS;
      halted = 1'b0;
   endfunction

   function automatic vm_result_t execute_instruction(input logic [7:0] op,
                                                      input logic [255:0] imm);
      vm_result_t  res;
      int unsigned need, adv, d, npc;
      logic [63:0] cost;
      bit          grows, known;
      logic [255:0] a, b, r, x;
      need = 0; cost = 3; adv = 1; grows = 0; known = 1;
      a = '0; b = '0; r = '0;
      res.status = ST_OK;
      if (halted) begin
         res.status = ST_HALTED;
      end else if (op == OP_STOP || op == OP_SDEST || op == OP_INVAL) begin
         res.status = (op == OP_INVAL) ? ST_INVALID : ST_STOPPED;
         halted = 1'b1;
      end else begin
         if (op == OP_ADD || op == OP_MUL || op == OP_SUB || op == OP_LT || op == OP_GT ||
             op == OP_EQ || op == OP_AND || op == OP_OR || op == OP_XOR || op == OP_SHL ||
             op == OP_SHR) begin
            need = 2;
            if (op == OP_MUL) cost = 5;
         end else if (op == OP_ISZERO || op == OP_NOT) begin
            need = 1;
         end else if (op == OP_POP) begin
            need = 1; cost = 2;
         end else if (op == OP_GASLIM || op == OP_PC || op == OP_GAS) begin
            grows = 1; cost = 2;
         end else if (op >= OP_PUSH1 && op <= OP_PUSH32) begin
            grows = 1; adv = 2 + op - OP_PUSH1;
         end else if (op >= OP_DUP1 && op <= OP_DUP16) begin
            grows = 1; need = 1 + op - OP_DUP1;
         end else if (op >= OP_SWAP1 && op <= OP_SWAP16) begin
            need = 2 + op - OP_SWAP1;
         end else begin
            known = 0;
         end

         if (!known) res.status = ST_UNSUPP;
         else if (depth < need) res.status = ST_UNDER;
         else if (grows && depth >= STACK_WORDS) res.status = ST_OVER;
         else begin
            d = depth;
            gas = gas - cost;
            if (need >= 1) a = stack_words[d-1];
            if (need == 2) b = stack_words[d-2];
            case (op)
               OP_ADD:    r = a + b;
               OP_MUL:    r = a * b;
               OP_SUB:    r = a - b;
               OP_LT:     r = (a < b) ? 256'd1 : 256'd0;
               OP_GT:     r = (a > b) ? 256'd1 : 256'd0;
               OP_EQ:     r = (a == b) ? 256'd1 : 256'd0;
               OP_ISZERO: r = (a == '0) ? 256'd1 : 256'd0;
               OP_AND:    r = a & b;
               OP_OR:     r = a | b;
               OP_XOR:    r = a ^ b;
               OP_NOT:    r = ~a;
               OP_SHL:    r = (a[255:8] != '0) ? '0 : (b << a[7:0]);
               OP_SHR:    r = (a[255:8] != '0) ? '0 : (b >> a[7:0]);
               OP_GASLIM: r = {192'd0, gas_limit};
               OP_PC:     r = {240'd0, pc};
               OP_GAS:    r = {192'd0, gas};
               default:   r = '0;
            endcase
            if (op >= OP_PUSH1 && op <= OP_PUSH32)
               r = imm & ({256{1'b1}} >> (256 - 8 * (adv - 1)));
            else if (op >= OP_DUP1 && op <= OP_DUP16)
               r = stack_words[d-need];

            if (op >= OP_SWAP1 && op <= OP_SWAP16) begin
               x = stack_words[d-1];
               stack_words[d-1] = stack_words[d-need];
               stack_words[d-need] = x;
            end else if (op == OP_POP) begin
               depth = d - 1;
            end else if (grows) begin
               stack_words[d] = r;
               depth = d + 1;
            end else if (need == 2) begin
               stack_words[d-2] = r;
               depth = d - 1;
            end else begin
               stack_words[d-1] = r;
            end
            npc = pc + adv;
            if (npc >= PROGRAM_BYTES) halted = 1'b1;
            pc = npc[15:0];
         end
      end
      res.top   = (depth > 0) ? stack_words[depth-1] : '0;
      res.count = depth[10:0];
      res.gas   = gas;
      res.pc    = pc;
      return res;
   endfunction

   always @(posedge clock) begin
      vm_result_t e;
      logic [255:0] got;
      if (reset) begin
         gas_limit = GAS_RESET;
         restart_machine();
         expected_results.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_top_w3, rsp_top_w2, rsp_top_w1, rsp_top_w0};
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result transaction: status %0d count %0d",
                           rsp_status, rsp_stack_count);
            end else begin
               e = expected_results.pop_front();
               if (rsp_status !== e.status || got !== e.top || rsp_stack_count !== e.count ||
                   rsp_gas_left !== e.gas || rsp_next_pc !== e.pc) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: exp st %0d top %h cnt %0d gas %h pc %h / got st %0d top %h cnt %0d gas %h pc %h",
                              e.status, e.top, e.count, e.gas, e.pc, rsp_status, got,
                              rsp_stack_count, rsp_gas_left, rsp_next_pc);
               end
            end
         end
         if (csr_we) begin
            gas_limit = csr_wdata;
            restart_machine();
         end
         if (req_valid && req_ready)
            expected_results.push_back(execute_instruction(req_mode,
               {req_imm_w3, req_imm_w2, req_imm_w1, req_imm_w0}));
      end
      pending_count = expected_results.size();
   end

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end
endmodule
`default_nettype wire

// ===== tb/stack_vm_256bit_executor_core_tb.sv =====
// Testbench top: drives instruction and configuration transactions and reports the verdict.
`timescale 1ns / 100ps
`default_nettype none
module stack_vm_256bit_executor_core_tb;
   import svm_pkg::*;

   localparam logic [7:0] OP_KECCAK = 8'h20;
   localparam logic [7:0] OP_MSTORE = 8'h52;
   localparam logic [7:0] OP_PUSH2  = OP_PUSH1 + 8'd1;
   localparam logic [7:0] OP_PUSH16 = OP_PUSH1 + 8'd15;
   localparam int         STALL_LIMIT = 5000;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic [63:0] csr_wdata = '0;
   logic        req_valid = 0;
   logic        req_ready;
   logic [7:0]  req_mode = '0;
   logic [63:0] req_imm_w0 = '0, req_imm_w1 = '0, req_imm_w2 = '0, req_imm_w3 = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [2:0]  rsp_status;
   logic [63:0] rsp_top_w0, rsp_top_w1, rsp_top_w2, rsp_top_w3;
   logic [10:0] rsp_stack_count;
   logic [63:0] rsp_gas_left;
   logic [15:0] rsp_next_pc;
   int          mismatch_count, pending_count;
   bit          idling_on = 1;
   int          stall_left = 0;
   int          quiet_cycles = 0;

   always #5 clock = ~clock;

   stack_vm_256bit_executor_core dut (.*);
   stack_vm_256bit_executor_core_checker chk (.*);

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 6);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic logic [255:0] random_operand();
      logic [255:0] v;
      for (int i = 0; i < 4; i++)
         case ($urandom_range(0, 5))
            0: v[i*64 +: 64] = '0;
            1: v[i*64 +: 64] = '1;
            default: v[i*64 +: 64] = {$urandom, $urandom};
         endcase
      return v;
   endfunction

   function automatic logic [7:0] random_opcode();
      int p;
      p = $urandom_range(0, 999);
      if (p < 300) return OP_PUSH1 + 8'($urandom_range(0, 31));
      if (p < 330) return OP_SHL + 8'($urandom_range(0, 1));
      if (p < 550) begin
         case ($urandom_range(0, 8))
            0: return OP_ADD;
            1: return OP_MUL;
            2: return OP_SUB;
            3: return OP_LT;
            4: return OP_GT;
            5: return OP_EQ;
            6: return OP_AND;
            7: return OP_OR;
            default: return OP_XOR;
         endcase
      end
      if (p < 600) return ($urandom_range(0, 1) != 0) ? OP_ISZERO : OP_NOT;
      if (p < 640) return OP_POP;
      if (p < 740) return OP_DUP1 + 8'($urandom_range(0, 15));
      if (p < 840) return OP_SWAP1 + 8'($urandom_range(0, 15));
      if (p < 880) begin
         case ($urandom_range(0, 2))
            0: return OP_GASLIM;
            1: return OP_PC;
            default: return OP_GAS;
         endcase
      end
      if (p < 996) return 8'($urandom_range(0, 255));
      case ($urandom_range(0, 2))
         0: return OP_STOP;
         1: return OP_INVAL;
         default: return OP_SDEST;
      endcase
   endfunction

   task automatic send(input logic [7:0] op, input logic [255:0] imm);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_mode   <= op;
      {req_imm_w3, req_imm_w2, req_imm_w1, req_imm_w0} <= imm;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_gas_limit(input logic [63:0] limit);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= limit;
      @(negedge clock);
      csr_we    <= 1'b0;
      @(negedge clock);
   endtask

   logic [63:0] limits [6];

   initial begin
      limits = '{64'd21000, 64'hFFFF_FFFF_FFFF_FFFF, 64'd21001, GAS_RESET, 64'd21003, 64'd0};
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send(OP_PUSH32, '1);
      send(OP_PUSH1, '1);
      send(OP_ADD, '0);
      send(OP_PUSH32, '1);
      send(OP_MUL, '0);
      send(OP_PUSH1, 256'h7);
      send(OP_SUB, '0);
      send(OP_DUP1, '0);
      send(OP_LT, '0);
      send(OP_PUSH16, random_operand());
      send(OP_GT, '0);
      send(OP_DUP1, '0);
      send(OP_EQ, '0);
      send(OP_ISZERO, '0);
      send(OP_PUSH32, random_operand());
      send(OP_AND, '0);
      send(OP_NOT, '0);
      send(OP_DUP1, '0);
      send(OP_OR, '0);
      send(OP_DUP1, '0);
      send(OP_XOR, '0);
      send(OP_PUSH2, 256'h100);
      send(OP_SHL, '0);
      send(OP_PUSH1, 256'h4);
      send(OP_SHR, '0);
      send(OP_GASLIM, '0);
      send(OP_PC, '0);
      send(OP_GAS, '0);
      send(OP_POP, '0);
      send(OP_DUP16, '0);
      send(OP_SWAP16, '0);
      send(OP_SWAP1, '0);
      send(OP_KECCAK, '0);
      send(OP_MSTORE, '0);
      send(OP_INVAL, '0);
      send(OP_ADD, '0);

      // Fill the stack, overflow it, then keep it near full for a while.
      write_gas_limit(64'd21000);
      for (int i = 0; i < STACK_WORDS; i++) send(OP_PUSH32, random_operand());
      send(OP_PUSH1, '1);
      send(OP_DUP1, '0);
      for (int i = 0; i < 20; i++) begin
         send(OP_POP, '0);
         send(OP_PUSH32, random_operand());
      end
      send(OP_PC, '0);

      for (int phase = 0; phase < 9; phase++) begin
         if (phase < 6) write_gas_limit(limits[phase]);
         else write_gas_limit({$urandom, $urandom});
         if (phase == 8) idling_on = 0;
         for (int i = 0; i < 28; i++) send(random_opcode(), random_operand());
      end
      send(OP_STOP, '0);
      send(OP_SDEST, '0);

      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      repeat (40) @(negedge clock);
      if (mismatch_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule
`default_nettype wire
